### rtl/cia_pkg.sv
package cia_pkg;

    localparam int DataW     = 64;
    localparam int DivStages = 64;
    localparam int MulLat    = 3;
    localparam int MulDly    = DivStages - MulLat;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_NEG = 3'd3,
        OP_DIV = 3'd4,
        OP_MOD = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    // control that travels alongside the divider
    typedef struct packed {
        logic             valid;
        logic [2:0]       op;
        logic             wide;
        logic             sa;
        logic             sb;
        logic [DataW-1:0] b;
        logic [DataW-1:0] simple_r;
        logic [1:0]       status;
    } t_side;

endpackage

### rtl/cia_mul.sv
module cia_mul
    import cia_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [DataW-1:0] i_ma,
    input  logic [DataW-1:0] i_mb,
    input  logic             i_neg,
    input  logic             i_wide,
    output logic [DataW-1:0] o_res,
    output logic             o_ovf
);

    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic         r_neg1, r_wide1, r_neg2, r_wide2;
    logic [127:0] r_prod;
    logic [63:0]  r_res;
    logic         r_ovf;
    logic [63:0]  n_limit;
    logic [127:0] n_prod;

    // stage 1: four 32x32 partial products
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p00   <= {32'd0, i_ma[31:0]}  * {32'd0, i_mb[31:0]};
            r_p01   <= {32'd0, i_ma[31:0]}  * {32'd0, i_mb[63:32]};
            r_p10   <= {32'd0, i_ma[63:32]} * {32'd0, i_mb[31:0]};
            r_p11   <= {32'd0, i_ma[63:32]} * {32'd0, i_mb[63:32]};
            r_neg1  <= i_neg;
            r_wide1 <= i_wide;
        end
    end

    // stage 2: sum into the full product
    always_comb begin
        n_prod = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
               + {r_p11, 64'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod  <= n_prod;
            r_neg2  <= r_neg1;
            r_wide2 <= r_wide1;
        end
    end

    // stage 3: range check and sign
    always_comb begin
        n_limit = (r_wide2 ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF)
                + {63'd0, r_neg2};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovf <= (r_prod[127:64] != 64'd0) || (r_prod[63:0] > n_limit);
            r_res <= r_neg2 ? (64'd0 - r_prod[63:0]) : r_prod[63:0];
        end
    end

    assign o_res = r_res;
    assign o_ovf = r_ovf;

endmodule

### rtl/cia_div.sv
module cia_div
    import cia_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  t_side            i_side,
    input  logic [DataW-1:0] i_ma,
    input  logic [DataW-1:0] i_mb,
    output t_side            o_side,
    output logic [DataW-1:0] o_quot,
    output logic [DataW-1:0] o_rem
);

    t_side            r_side [DivStages];
    logic [DataW-1:0] r_rem  [DivStages];
    logic [DataW-1:0] r_dvd  [DivStages];
    logic [DataW-1:0] r_mb   [DivStages];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < DivStages; k++) begin : g_stage
        t_side            p_side;
        logic [DataW-1:0] p_rem, p_dvd, p_mb;
        logic [DataW:0]   n_t, n_d;

        if (k == 0) begin : g_first
            assign p_side = i_side;
            assign p_rem  = '0;
            assign p_dvd  = i_ma;
            assign p_mb   = i_mb;
        end else begin : g_next
            assign p_side = r_side[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_dvd  = r_dvd[k-1];
            assign p_mb   = r_mb[k-1];
        end

        always_comb begin
            n_t = {p_rem, p_dvd[DataW-1]};
            n_d = n_t - {1'b0, p_mb};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else if (i_ce) begin
                r_side[k].valid <= p_side.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_side[k].op       <= p_side.op;
                r_side[k].wide     <= p_side.wide;
                r_side[k].sa       <= p_side.sa;
                r_side[k].sb       <= p_side.sb;
                r_side[k].b        <= p_side.b;
                r_side[k].simple_r <= p_side.simple_r;
                r_side[k].status   <= p_side.status;
                r_mb[k]            <= p_mb;
                r_rem[k]           <= n_d[DataW] ? n_t[DataW-1:0] : n_d[DataW-1:0];
                r_dvd[k]           <= {p_dvd[DataW-2:0], ~n_d[DataW]};
            end
        end
    end

    assign o_side = r_side[DivStages-1];
    assign o_quot = r_dvd[DivStages-1];
    assign o_rem  = r_rem[DivStages-1];

    // remainder always ends below a nonzero divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side[DivStages-1].valid && (r_mb[DivStages-1] != '0)
        |-> (o_rem < r_mb[DivStages-1]))
        else $error("divider remainder not below divisor");

    // an empty slot stays empty down the pipe
    a_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ce && !r_side[0].valid |=> !r_side[1].valid)
        else $error("divider bubble gained a valid bit");

    // a stalled pipe holds its last quotient
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ce |=> $stable(o_quot) && $stable(o_rem))
        else $error("divider moved during stall");

endmodule

### rtl/checked_integer_alu_top.sv
// Checked signed integer ALU: add, subtract, multiply, negate, floor divide and
// floor modulo on 32-bit or 64-bit operands with overflow and divide-by-zero
// status. Fully pipelined: one transaction per cycle unless the output stalls;
// its stages are input, operand, 64 radix-2 divider stages and output; the
// 64-stage divider sets the depth and every opcode takes the same path length.
// A stalled output freezes the whole pipe and no transaction is lost.
module checked_integer_alu_top
    import cia_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [127:0]   i_s_tdata,   // operand_a[63:0], operand_b[127:64]
    input  logic [3:0]     i_s_tuser,   // opcode[2:0], wide_mode[3]
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [63:0]    o_m_tdata,   // result_value[63:0]
    output logic [1:0]     o_m_tuser    // status[1:0]
);

    logic             ce;
    logic             r_out_valid;
    logic [DataW-1:0] r_out_data;
    logic [1:0]       r_out_status;

    // stage a: registered and sign-extended inputs
    logic             r_a_valid, r_a_wide;
    logic [2:0]       r_a_op;
    logic [DataW-1:0] r_a_a, r_a_b;

    // stage b: magnitudes and simple results
    t_side            r_b_side;
    logic [DataW-1:0] r_b_ma, r_b_mb;
    t_side            n_b_side;

    t_side            d_side;
    logic [DataW-1:0] d_quot, d_rem;
    logic [DataW-1:0] m_res;
    logic             m_ovf;
    logic [DataW-1:0] r_mdly_res [MulDly];
    logic             r_mdly_ovf [MulDly];

    logic [DataW-1:0] n_sum, n_dif, n_ngt, n_r, n_rt, n_fin;
    logic [1:0]       n_st;
    logic             n_opp, n_remnz;

    assign ce         = !r_out_valid || i_m_tready;
    assign o_s_tready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ce) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_op   <= i_s_tuser[2:0];
            r_a_wide <= i_s_tuser[3];
            r_a_a    <= i_s_tuser[3] ? i_s_tdata[63:0]
                                     : {{32{i_s_tdata[31]}}, i_s_tdata[31:0]};
            r_a_b    <= i_s_tuser[3] ? i_s_tdata[127:64]
                                     : {{32{i_s_tdata[95]}}, i_s_tdata[95:64]};
        end
    end

    // add, subtract, negate and their overflow checks, plus the divide-by-zero check
    always_comb begin
        n_sum = r_a_a + r_a_b;
        n_dif = r_a_a - r_a_b;
        n_ngt = 64'd0 - r_a_a;
        n_b_side          = '0;
        n_b_side.valid    = r_a_valid;
        n_b_side.op       = r_a_op;
        n_b_side.wide     = r_a_wide;
        n_b_side.sa       = r_a_a[63];
        n_b_side.sb       = r_a_b[63];
        n_b_side.b        = r_a_b;
        n_b_side.status   = ST_OK;
        n_b_side.simple_r = '0;
        unique case (r_a_op)
            OP_ADD: begin
                n_b_side.simple_r = n_sum;
                if (r_a_wide ? ((r_a_a[63] ~^ r_a_b[63]) && (n_sum[63] != r_a_a[63]))
                             : (n_sum[63:31] != {33{n_sum[31]}}))
                    n_b_side.status = ST_OVF;
            end
            OP_SUB: begin
                n_b_side.simple_r = n_dif;
                if (r_a_wide ? ((r_a_a[63] ^ r_a_b[63]) && (n_dif[63] != r_a_a[63]))
                             : (n_dif[63:31] != {33{n_dif[31]}}))
                    n_b_side.status = ST_OVF;
            end
            OP_NEG: begin
                n_b_side.simple_r = n_ngt;
                if (r_a_wide ? (r_a_a == 64'h8000_0000_0000_0000)
                             : (n_ngt[63:31] != {33{n_ngt[31]}}))
                    n_b_side.status = ST_OVF;
            end
            OP_DIV, OP_MOD: begin
                if (r_a_b == '0)
                    n_b_side.status = ST_DIVZ;
            end
            default: begin
                n_b_side.simple_r = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side.valid <= 1'b0;
        end else if (ce) begin
            r_b_side.valid <= n_b_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_b_side.op       <= n_b_side.op;
            r_b_side.wide     <= n_b_side.wide;
            r_b_side.sa       <= n_b_side.sa;
            r_b_side.sb       <= n_b_side.sb;
            r_b_side.b        <= n_b_side.b;
            r_b_side.simple_r <= n_b_side.simple_r;
            r_b_side.status   <= n_b_side.status;
            r_b_ma            <= r_a_a[63] ? (64'd0 - r_a_a) : r_a_a;
            r_b_mb            <= r_a_b[63] ? (64'd0 - r_a_b) : r_a_b;
        end
    end

    cia_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_side  (r_b_side),
        .i_ma    (r_b_ma),
        .i_mb    (r_b_mb),
        .o_side  (d_side),
        .o_quot  (d_quot),
        .o_rem   (d_rem)
    );

    cia_mul u_mul (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_ma   (r_b_ma),
        .i_mb   (r_b_mb),
        .i_neg  (r_b_side.sa ^ r_b_side.sb),
        .i_wide (r_b_side.wide),
        .o_res  (m_res),
        .o_ovf  (m_ovf)
    );

    // align the product with the divider output
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_mdly_res[0] <= m_res;
            r_mdly_ovf[0] <= m_ovf;
            for (int i = 1; i < MulDly; i++) begin
                r_mdly_res[i] <= r_mdly_res[i-1];
                r_mdly_ovf[i] <= r_mdly_ovf[i-1];
            end
        end
    end

    // floor correction and result select
    always_comb begin
        n_opp   = d_side.sa ^ d_side.sb;
        n_remnz = (d_rem != '0);
        n_rt    = d_side.sa ? (64'd0 - d_rem) : d_rem;
        n_r     = '0;
        n_st    = d_side.status;
        unique case (d_side.op)
            OP_ADD, OP_SUB, OP_NEG: n_r = d_side.simple_r;
            OP_MUL: begin
                n_r  = r_mdly_res[MulDly-1];
                n_st = r_mdly_ovf[MulDly-1] ? ST_OVF : ST_OK;
            end
            OP_DIV: n_r = n_opp ? (n_remnz ? ~d_quot : (64'd0 - d_quot)) : d_quot;
            OP_MOD: n_r = (n_remnz && n_opp) ? (n_rt + d_side.b) : n_rt;
            default: begin
                n_r  = '0;
                n_st = ST_OK;
            end
        endcase
        if (n_st != ST_OK)
            n_fin = '0;
        else if (!d_side.wide)
            n_fin = {{32{n_r[31]}}, n_r[31:0]};
        else
            n_fin = n_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= d_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_data   <= n_fin;
            r_out_status <= n_st;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    // any error status comes with a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_OK) |-> (o_m_tdata == '0))
        else $error("error status with nonzero result");

    // status code three never appears
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser != 2'd3))
        else $error("unused status code on output");

    // a new output transaction comes from a valid divider slot
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(d_side.valid))
        else $error("output valid without source");

endmodule

### bench/tb_checked_integer_alu_top.sv
module tb_checked_integer_alu_top;
    import cia_pkg::*;

    localparam int PipeLat   = 67;
    localparam int NumRandom = 1750;

    // expected alu output
    typedef struct {
        logic [63:0] value;
        t_status     status;
    } t_alu_out;

    // predicts alu results and compares them with what comes out
    class alu_scoreboard;
        t_alu_out pending[$];
        int       mismatches;

        function automatic logic [63:0] sx32(logic [63:0] v);
            return {{32{v[31]}}, v[31:0]};
        endfunction

        function automatic logic [63:0] mag(logic [63:0] v);
            return v[63] ? (64'd0 - v) : v;
        endfunction

        function void note_operation(logic [2:0] op, logic wide, logic [63:0] in_a,
                                     logic [63:0] in_b);
            logic [63:0]  a, b, r, ma, mb, q, rem, fq, lim;
            logic [127:0] prod;
            logic         opp;
            t_status      st;
            t_alu_out     e;
            a   = wide ? in_a : sx32(in_a);
            b   = wide ? in_b : sx32(in_b);
            r   = '0;
            st  = ST_OK;
            opp = a[63] != b[63];
            case (op)
                OP_ADD: begin
                    r = a + b;
                    if (wide ? ((a ^ r) & (b ^ r)) >> 63 != 0 : sx32(r) != r) st = ST_OVF;
                end
                OP_SUB: begin
                    r = a - b;
                    if (wide ? ((a ^ b) & (a ^ r)) >> 63 != 0 : sx32(r) != r) st = ST_OVF;
                end
                OP_MUL: begin
                    // full double-width magnitude product against the signed limit
                    prod = {64'd0, mag(a)} * {64'd0, mag(b)};
                    lim  = wide ? 64'h7fff_ffff_ffff_ffff : 64'h7fff_ffff;
                    if (opp) lim = lim + 64'd1;
                    if (prod[127:64] != 0 || prod[63:0] > lim) st = ST_OVF;
                    else r = opp ? (64'd0 - prod[63:0]) : prod[63:0];
                end
                OP_NEG: begin
                    r = 64'd0 - a;
                    if (wide ? a == 64'h8000_0000_0000_0000 : sx32(r) != r) st = ST_OVF;
                end
                OP_DIV, OP_MOD: begin
                    if (b == 0) begin
                        st = ST_DIVZ;
                    end else begin
                        // truncate on magnitudes, then step toward minus infinity
                        ma  = mag(a);
                        mb  = mag(b);
                        q   = ma / mb;
                        rem = ma % mb;
                        fq  = opp ? (64'd0 - q) : q;
                        if (rem != 0 && opp) fq = fq - 64'd1;
                        r = (op == OP_DIV) ? fq : a - fq * b;
                    end
                end
                default: r = '0;
            endcase
            if (st != ST_OK) r = '0;
            else if (!wide) r = sx32(r);
            e.value  = r;
            e.status = st;
            pending.push_back(e);
        endfunction

        function void check_result(logic [63:0] value, logic [1:0] status);
            t_alu_out e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h status=%0d", value, status);
                return;
            end
            e = pending.pop_front();
            if (value !== e.value || status !== e.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                             e.value, e.status, value, status);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;    // operand_a[63:0], operand_b[127:64]
    logic [3:0]   i_s_tuser = '0;    // opcode[2:0], wide_mode[3]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [63:0]  o_m_tdata;         // result_value[63:0]
    logic [1:0]   o_m_tuser;         // status[1:0]

    alu_scoreboard sb = new();
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    checked_integer_alu_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    // one operation; valid stays high across back-to-back transactions
    task automatic send_op(logic [2:0] op, logic wide, logic [63:0] a, logic [63:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {b, a};
        i_s_tuser  = {wide, op};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_operation(op, wide, a, b);
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain();
        go_quiet();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // operand mix weighted toward the interesting corners
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(11))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = {v[63:32], 32'h8000_0000};
            3: v = {v[63:32], 32'h7fff_ffff};
            4: v = '1;
            5: v = {$urandom_range(1) ? 60'd0 : '1, 4'(v)};
            6: v = {{32{v[31]}}, v[31:0]};
            7: v = {{48{v[15]}}, v[15:0]};
            8: v = 64'(signed'(v[7:0]));
            default: ;
        endcase
        return v;
    endfunction

    localparam logic [63:0] Min64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] Max64 = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] Min32 = 64'hffff_ffff_8000_0000;
    localparam logic [63:0] Max32 = 64'h0000_0000_7fff_ffff;
    localparam logic [63:0] MinusOne = '1;

    initial begin
        int idle_set[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{7, 7}};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        send_op(OP_ADD, 1'b1, Max64, 64'd1);
        send_op(OP_ADD, 1'b0, Max32, 64'd1);
        send_op(OP_ADD, 1'b1, Min64, Max64);
        send_op(OP_SUB, 1'b1, Min64, 64'd1);
        send_op(OP_SUB, 1'b0, Min32, 64'd1);
        send_op(OP_MUL, 1'b1, Max64, 64'd2);
        send_op(OP_MUL, 1'b1, Min64, MinusOne);
        send_op(OP_MUL, 1'b1, Min64, 64'd1);
        send_op(OP_MUL, 1'b0, Min32, MinusOne);
        send_op(OP_MUL, 1'b0, 64'h1_0000, 64'hffff_ffff_ffff_8000);
        send_op(OP_NEG, 1'b1, Min64, 64'd5);
        send_op(OP_NEG, 1'b0, Min32, 64'd0);
        send_op(OP_NEG, 1'b0, Max32, Max64);
        send_op(OP_DIV, 1'b1, Min64, MinusOne);
        send_op(OP_DIV, 1'b0, Min32, MinusOne);
        send_op(OP_MOD, 1'b1, Min64, MinusOne);
        send_op(OP_MOD, 1'b0, Min32, MinusOne);
        send_op(OP_DIV, 1'b1, 64'd7, 64'd0);
        send_op(OP_MOD, 1'b0, 64'd7, 64'h1234_5678_0000_0000);   // zero after narrowing
        send_op(OP_DIV, 1'b1, -64'sd7, 64'd2);
        send_op(OP_MOD, 1'b1, -64'sd7, 64'd2);
        send_op(OP_MOD, 1'b0, 64'd7, -64'sd2);
        send_op(3'd6, 1'b1, Max64, Max64);
        send_op(3'd7, 1'b0, Min64, MinusOne);
        send_op(OP_ADD, 1'b0, 64'hdead_beef_0000_0005, 64'h1234_5678_0000_0003);
        drain();

        // random phases with different idle and stall patterns
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_set[p][0];
            recv_stall_pct = idle_set[p][1];
            for (int n = 0; n < NumRandom / 4; n++)
                send_op(3'($urandom_range(7)), 1'($urandom_range(1)),
                        pick_operand(), pick_operand());
            drain();
        end

        recv_stall_pct = 0;
        repeat (PipeLat + 20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[checked_integer_alu_top] OK");
        end else begin
            $display("[checked_integer_alu_top] ERROR");
        end
        $finish;
    end

    // run time limit
    initial begin
        #2000000;
        $display("[checked_integer_alu_top] ERROR");
        $finish;
    end

endmodule
